FILE: design/ubx_nav_pvt_frame_receiver_core_defines.svh
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_receiver_core_defines
// Assertion macros shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef UBX_NAV_PVT_FRAME_RECEIVER_CORE_DEFINES_SVH
`define UBX_NAV_PVT_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define UBXR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication, checked out of reset
`define UBXR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

FILE: design/ubxr_pkg.sv
// ----------------------------------------------------------------------------
// ubxr_pkg
// Types and constants for the navigation frame receiver.
// ----------------------------------------------------------------------------
package ubxr_pkg;

    // Input transfer: one stream byte plus restart flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    // Output transfer: one decoded field
    typedef struct packed {
        logic [4:0]         field_code;
        logic signed [31:0] field_value;
        logic               last_field;
    } t_out_item;

    // Framing constants
    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [15:0] PVT_MIN_LEN = 16'd92;

    // Register indexes
    localparam logic REG_CLASS = 1'b0;
    localparam logic REG_ID    = 1'b1;
    localparam logic [7:0] CLASS_RESET = 8'h01;
    localparam logic [7:0] ID_RESET    = 8'h07;

    // Field codes
    localparam logic [4:0] FC_LENGTH  = 5'd0;
    localparam logic [4:0] FC_YEAR    = 5'd1;
    localparam logic [4:0] FC_MONTH   = 5'd2;
    localparam logic [4:0] FC_DAY     = 5'd3;
    localparam logic [4:0] FC_HOUR    = 5'd4;
    localparam logic [4:0] FC_MINUTE  = 5'd5;
    localparam logic [4:0] FC_SECOND  = 5'd6;
    localparam logic [4:0] FC_TFLAGS  = 5'd7;
    localparam logic [4:0] FC_FIXTYPE = 5'd8;
    localparam logic [4:0] FC_FIXOK   = 5'd9;
    localparam logic [4:0] FC_NUMSV   = 5'd10;
    localparam logic [4:0] FC_LON     = 5'd11;
    localparam logic [4:0] FC_LAT     = 5'd12;
    localparam logic [4:0] FC_HEIGHT  = 5'd13;
    localparam logic [4:0] FC_SPEED   = 5'd14;
    localparam logic [4:0] FC_HEADING = 5'd15;
    localparam logic [4:0] FC_DOP     = 5'd16;

    // Payload byte offsets that are kept; slot k holds payload byte CAP_OFFS[k]
    localparam int CAP_SLOTS = 33;
    localparam logic [6:0] CAP_OFFS [CAP_SLOTS] = '{
        7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
        7'd20, 7'd21, 7'd23,
        7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31,
        7'd36, 7'd37, 7'd38, 7'd39,
        7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67,
        7'd76, 7'd77
    };

    // Slot of the low byte of each field
    localparam int SL_YEAR    = 0;
    localparam int SL_MONTH   = 2;
    localparam int SL_DAY     = 3;
    localparam int SL_HOUR    = 4;
    localparam int SL_MINUTE  = 5;
    localparam int SL_SECOND  = 6;
    localparam int SL_TFLAGS  = 7;
    localparam int SL_FIXTYPE = 8;
    localparam int SL_FIXOK   = 9;
    localparam int SL_NUMSV   = 10;
    localparam int SL_LON     = 11;
    localparam int SL_LAT     = 15;
    localparam int SL_HEIGHT  = 19;
    localparam int SL_SPEED   = 23;
    localparam int SL_HEADING = 27;
    localparam int SL_DOP     = 31;

endpackage

FILE: design/ubx_nav_pvt_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_receiver_core
// Byte-stream frame parser with Fletcher check and field burst output.
// ----------------------------------------------------------------------------
// Takes one byte per cycle; parse state updates at the byte's transfer.
// The first result of a good frame is shown the cycle after its last
// checksum byte; the 17 results then leave at one per cycle unless stalled.
// Input stalls only on a closing checksum byte while the previous burst is
// still going out. Reset (i_rst_n, synchronous) returns to sync hunting,
// clears the output burst and reloads class 0x01 and id 0x07.
module ubx_nav_pvt_frame_receiver_core
    import ubxr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 248
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // Decoded fields
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "ubx_nav_pvt_frame_receiver_core_defines.svh"

    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    // Parser phases
    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [7:0]    r_exp_class;
    logic [7:0]    r_exp_id;

    logic [3:0]    r_phase,  n_phase;
    logic [CW-1:0] r_count,  n_count;
    logic [15:0]   r_len,    n_len;
    logic [7:0]    r_sum_a,  n_sum_a;
    logic [7:0]    r_sum_b,  n_sum_b;
    logic          r_ck_a,   n_ck_a;

    logic [7:0]    r_cap  [CAP_SLOTS];
    logic [7:0]    r_snap [CAP_SLOTS];
    logic [15:0]   r_snap_len;

    logic          r_busy;
    logic [4:0]    r_idx;

    logic          in_xfer;
    logic          out_xfer;
    logic          frame_ok;
    logic [3:0]    cur_phase;
    logic [7:0]    in_byte;
    logic [7:0]    sum_a_add;
    logic [7:0]    sum_b_add;
    logic [CW-1:0] count_inc;
    logic [15:0]   len_full;
    logic          cfg_wr;
    logic signed [31:0] fld_value;

    // ------------------------------------------------------------------
    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ID) ? {24'd0, r_exp_id} : {24'd0, r_exp_class};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_class <= CLASS_RESET;
            r_exp_id    <= ID_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CLASS) begin
                r_exp_class <= pwdata[7:0];
            end else begin
                r_exp_id <= pwdata[7:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    assign o_in_stall = r_busy && (r_phase == PH_CK_B);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_busy && !i_out_stall;

    // ------------------------------------------------------------------
    // Parser next state
    assign in_byte   = i_in_data.data_byte;
    assign cur_phase = i_in_data.restart ? PH_HUNT1 : r_phase;
    assign sum_a_add = r_sum_a + in_byte;
    assign sum_b_add = r_sum_b + sum_a_add;
    assign count_inc = r_count + CW'(1);
    assign len_full  = {in_byte, r_len[7:0]};

    always_comb begin
        n_phase = cur_phase;
        n_count = r_count;
        n_len   = r_len;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_ck_a  = r_ck_a;
        case (cur_phase)
            PH_HUNT1: begin
                if (in_byte == SYNC_FIRST) n_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                if (in_byte == SYNC_SECOND) begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                    n_phase = PH_CLASS;
                end else if (in_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                if (in_byte == r_exp_class) begin
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_ID: begin
                if (in_byte == r_exp_id) begin
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_phase = PH_LEN_LO;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN_LO: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_len   = {8'd0, in_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_len   = len_full;
                n_count = '0;
                if (len_full > 16'(MAX_PAYLOAD)) begin
                    n_phase = PH_HUNT1;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_count = count_inc;
                if (16'(count_inc) >= r_len) n_phase = PH_CK_A;
            end
            PH_CK_A: begin
                n_ck_a  = (in_byte == r_sum_a);
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                n_phase = PH_HUNT1;
            end
            default: begin
                n_phase = PH_HUNT1;
            end
        endcase
    end

    assign frame_ok = in_xfer && (cur_phase == PH_CK_B) && r_ck_a
                      && (in_byte == r_sum_b) && (r_len >= PVT_MIN_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_count <= '0;
            r_len   <= 16'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_ck_a  <= 1'b0;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ck_a  <= n_ck_a;
        end
    end

    // ------------------------------------------------------------------
    // Keep only the payload bytes that feed a field
    for (genvar k = 0; k < CAP_SLOTS; k++) begin : g_cap
        always_ff @(posedge i_clk) begin
            if (in_xfer && (cur_phase == PH_PAYLOAD) && (r_count == CW'(CAP_OFFS[k]))) begin
                r_cap[k] <= in_byte;
            end
        end
    end

    // Snapshot on a good frame so the next frame can refill the capture
    always_ff @(posedge i_clk) begin
        if (frame_ok) begin
            r_snap     <= r_cap;
            r_snap_len <= r_len;
        end
    end

    // ------------------------------------------------------------------
    // Result burst sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= FC_LENGTH;
        end else if (frame_ok) begin
            r_busy <= 1'b1;
            r_idx  <= FC_LENGTH;
        end else if (out_xfer) begin
            if (r_idx == FC_DOP) r_busy <= 1'b0;
            r_idx <= r_idx + 5'd1;
        end
    end

    // Field select from the snapshot
    always_comb begin
        case (r_idx)
            FC_LENGTH:  fld_value = {16'd0, r_snap_len};
            FC_YEAR:    fld_value = {16'd0, r_snap[SL_YEAR+1], r_snap[SL_YEAR]};
            FC_MONTH:   fld_value = {24'd0, r_snap[SL_MONTH]};
            FC_DAY:     fld_value = {24'd0, r_snap[SL_DAY]};
            FC_HOUR:    fld_value = {24'd0, r_snap[SL_HOUR]};
            FC_MINUTE:  fld_value = {24'd0, r_snap[SL_MINUTE]};
            FC_SECOND:  fld_value = {24'd0, r_snap[SL_SECOND]};
            FC_TFLAGS:  fld_value = {24'd0, r_snap[SL_TFLAGS]};
            FC_FIXTYPE: fld_value = {24'd0, r_snap[SL_FIXTYPE]};
            FC_FIXOK:   fld_value = {31'd0, r_snap[SL_FIXOK][0]};
            FC_NUMSV:   fld_value = {24'd0, r_snap[SL_NUMSV]};
            FC_LON:     fld_value = {r_snap[SL_LON+3], r_snap[SL_LON+2],
                                     r_snap[SL_LON+1], r_snap[SL_LON]};
            FC_LAT:     fld_value = {r_snap[SL_LAT+3], r_snap[SL_LAT+2],
                                     r_snap[SL_LAT+1], r_snap[SL_LAT]};
            FC_HEIGHT:  fld_value = {r_snap[SL_HEIGHT+3], r_snap[SL_HEIGHT+2],
                                     r_snap[SL_HEIGHT+1], r_snap[SL_HEIGHT]};
            FC_SPEED:   fld_value = {r_snap[SL_SPEED+3], r_snap[SL_SPEED+2],
                                     r_snap[SL_SPEED+1], r_snap[SL_SPEED]};
            FC_HEADING: fld_value = {r_snap[SL_HEADING+3], r_snap[SL_HEADING+2],
                                     r_snap[SL_HEADING+1], r_snap[SL_HEADING]};
            FC_DOP:     fld_value = {16'd0, r_snap[SL_DOP+1], r_snap[SL_DOP]};
            default:    fld_value = 32'sd0;
        endcase
    end

    assign o_out_valid            = r_busy;
    assign o_out_data.field_code  = r_idx;
    assign o_out_data.field_value = fld_value;
    assign o_out_data.last_field  = (r_idx == FC_DOP);

    // ------------------------------------------------------------------
    // Checks
    `UBXR_ASSERT_NEXT(a_burst_ends, i_clk, i_rst_n,
        out_xfer && (r_idx == FC_DOP), !o_out_valid)
    `UBXR_ASSERT_NEXT(a_burst_starts, i_clk, i_rst_n,
        frame_ok, o_out_valid && (o_out_data.field_code == FC_LENGTH))
    `UBXR_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n,
        r_busy, !frame_ok)
    `UBXR_ASSERT_IMPL(a_payload_len, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, (r_len != 16'd0) && (16'(r_count) < r_len))

endmodule

FILE: sim/ubx_nav_pvt_frame_receiver_core_checker.sv
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_receiver_core_checker
// Watches the byte stream, the field outputs and the register port of the
// frame receiver. It runs its own frame parser on every accepted byte and
// queues the field burst a good frame must produce. Each accepted field is
// compared with the oldest queued one. Register reads are checked against
// the last value written.
// ----------------------------------------------------------------------------
module ubx_nav_pvt_frame_receiver_core_checker
    import ubxr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 248
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    // Decoded fields
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    // Register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    // Status for the testbench top
    output int          o_errors,
    output int          o_pending,
    output int          o_fields_seen,
    output int          o_frames_seen
);

    localparam int         STORE_DEPTH = 80;
    localparam int         MAX_REPORTS = 10;
    localparam logic [2:0] ADDR_CLASS  = {REG_CLASS, 2'b00};
    localparam logic [2:0] ADDR_ID     = {REG_ID, 2'b00};

    typedef enum logic [3:0] {
        ST_SYNC1, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN_LO, ST_LEN_HI,
        ST_BODY, ST_CK_A, ST_CK_B
    } t_rx_state;

    // Parser copy
    t_rx_state  rx_state;
    logic [7:0] want_class;
    logic [7:0] want_id;
    logic [15:0] body_count;
    logic [15:0] frame_len;
    logic [7:0] run_a;
    logic [7:0] run_b;
    logic       ck_a_ok;
    logic [7:0] body_store [STORE_DEPTH];

    // Fields still owed by the block, oldest first
    t_out_item  fields_due [$];
    t_out_item  due_field;

    int         errors      = 0;
    int         fields_seen = 0;
    int         frames_seen = 0;

    // Count a failure; only the first few are printed
    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic clear_parser();
        rx_state   = ST_SYNC1;
        want_class = CLASS_RESET;
        want_id    = ID_RESET;
        body_count = '0;
        frame_len  = '0;
        run_a      = '0;
        run_b      = '0;
        ck_a_ok    = 1'b0;
        foreach (body_store[k]) body_store[k] = '0;
        fields_due.delete();
    endtask

    // Fletcher-8 accumulate
    task automatic fold_sum(input logic [7:0] b);
        run_a = run_a + b;
        run_b = run_b + run_a;
    endtask

    function automatic logic [15:0] le16(input int off);
        return {body_store[off + 1], body_store[off]};
    endfunction

    function automatic logic [31:0] le32(input int off);
        return {le16(off + 2), le16(off)};
    endfunction

    task automatic queue_field(input logic [4:0] code, input logic [31:0] val,
                               input logic last);
        t_out_item f;
        f.field_code  = code;
        f.field_value = val;
        f.last_field  = last;
        fields_due.push_back(f);
    endtask

    // The burst of one good navigation frame, in output order
    task automatic queue_pvt_fields();
        queue_field(FC_LENGTH,  {16'h0000, frame_len},          1'b0);
        queue_field(FC_YEAR,    {16'h0000, le16(4)},            1'b0);
        queue_field(FC_MONTH,   {24'h000000, body_store[6]},    1'b0);
        queue_field(FC_DAY,     {24'h000000, body_store[7]},    1'b0);
        queue_field(FC_HOUR,    {24'h000000, body_store[8]},    1'b0);
        queue_field(FC_MINUTE,  {24'h000000, body_store[9]},    1'b0);
        queue_field(FC_SECOND,  {24'h000000, body_store[10]},   1'b0);
        queue_field(FC_TFLAGS,  {24'h000000, body_store[11]},   1'b0);
        queue_field(FC_FIXTYPE, {24'h000000, body_store[20]},   1'b0);
        queue_field(FC_FIXOK,   {31'h0, body_store[21][0]},     1'b0);
        queue_field(FC_NUMSV,   {24'h000000, body_store[23]},   1'b0);
        queue_field(FC_LON,     le32(24),                       1'b0);
        queue_field(FC_LAT,     le32(28),                       1'b0);
        queue_field(FC_HEIGHT,  le32(36),                       1'b0);
        queue_field(FC_SPEED,   le32(60),                       1'b0);
        queue_field(FC_HEADING, le32(64),                       1'b0);
        queue_field(FC_DOP,     {16'h0000, le16(76)},           1'b1);
    endtask

    // One accepted stream byte through the parser
    task automatic parse_byte(input t_in_item it);
        logic [7:0]  b;
        logic [15:0] len;
        b = it.data_byte;
        if (it.restart) begin
            rx_state = ST_SYNC1;
        end
        case (rx_state)
            ST_SYNC1: begin
                if (b == SYNC_FIRST) rx_state = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    run_a    = '0;
                    run_b    = '0;
                    rx_state = ST_CLASS;
                end else if (b != SYNC_FIRST) begin
                    rx_state = ST_SYNC1;
                end
            end
            ST_CLASS: begin
                if (b == want_class) begin
                    fold_sum(b);
                    rx_state = ST_ID;
                end else begin
                    rx_state = ST_SYNC1;
                end
            end
            ST_ID: begin
                if (b == want_id) begin
                    fold_sum(b);
                    rx_state = ST_LEN_LO;
                end else begin
                    rx_state = ST_SYNC1;
                end
            end
            ST_LEN_LO: begin
                fold_sum(b);
                frame_len = {8'h00, b};
                rx_state  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                fold_sum(b);
                len        = {b, frame_len[7:0]};
                frame_len  = len;
                body_count = '0;
                if (int'(len) > MAX_PAYLOAD) rx_state = ST_SYNC1;
                else if (len == 16'd0)       rx_state = ST_CK_A;
                else                         rx_state = ST_BODY;
            end
            ST_BODY: begin
                // bytes past the store still enter the checksum
                if (body_count < STORE_DEPTH) body_store[body_count] = b;
                fold_sum(b);
                body_count = body_count + 16'd1;
                if (body_count >= frame_len) rx_state = ST_CK_A;
            end
            ST_CK_A: begin
                ck_a_ok  = (b == run_a);
                rx_state = ST_CK_B;
            end
            ST_CK_B: begin
                rx_state = ST_SYNC1;
                if (ck_a_ok && b == run_b && frame_len >= PVT_MIN_LEN) begin
                    queue_pvt_fields();
                end
            end
            default: rx_state = ST_SYNC1;
        endcase
    endtask

    // Sample everything at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_CLASS) want_class = i_pwdata[7:0];
                else if (i_paddr == ADDR_ID) want_id = i_pwdata[7:0];
            end
            // register read back
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                if (i_paddr == ADDR_CLASS && i_prdata !== {24'h0, want_class}) begin
                    note_mismatch($sformatf("class register read %h, expected %h",
                                            i_prdata, want_class));
                end else if (i_paddr == ADDR_ID && i_prdata !== {24'h0, want_id}) begin
                    note_mismatch($sformatf("id register read %h, expected %h",
                                            i_prdata, want_id));
                end
            end
            // byte transfer
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_in_data);
            end
            // field transfer
            if (i_out_valid && !i_out_stall) begin
                if (fields_due.size() == 0) begin
                    note_mismatch($sformatf("field with none due: code %0d value %0d last %0b",
                                            i_out_data.field_code, i_out_data.field_value,
                                            i_out_data.last_field));
                end else begin
                    due_field = fields_due.pop_front();
                    if (i_out_data.field_code !== due_field.field_code ||
                        i_out_data.field_value !== due_field.field_value ||
                        i_out_data.last_field !== due_field.last_field) begin
                        note_mismatch($sformatf(
                            "expected code %0d value %0d last %0b, got code %0d value %0d last %0b",
                            due_field.field_code, due_field.field_value, due_field.last_field,
                            i_out_data.field_code, i_out_data.field_value,
                            i_out_data.last_field));
                    end
                end
                fields_seen++;
                if (i_out_data.last_field === 1'b1) frames_seen++;
            end
        end
        o_errors      <= errors;
        o_pending     <= fields_due.size();
        o_fields_seen <= fields_seen;
        o_frames_seen <= frames_seen;
    end

endmodule

FILE: sim/ubx_nav_pvt_frame_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_receiver_core_tb
// Stream stimulus and verdict for the navigation frame receiver. A directed
// set of frames covers sync, match, length, checksum and restart corners;
// a random phase then mixes good frames with broken ones and line noise
// under another class/id setting, and a last pair of frames runs with no idling.
// Checking is done by the checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module ubx_nav_pvt_frame_receiver_core_tb;
    import ubxr_pkg::*;

    localparam int         MAX_LEN       = 248;
    localparam int         MIN_LEN       = int'(PVT_MIN_LEN);
    localparam int         PHASE_BYTES   = 40;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         RUN_LIMIT     = 5_000_000;
    localparam logic [2:0] ADDR_CLASS    = {REG_CLASS, 2'b00};
    localparam logic [2:0] ADDR_ID       = {REG_ID, 2'b00};

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_SYNCS} t_fill;
    typedef enum {CK_GOOD, CK_BAD_A, CK_BAD_B, CK_BAD_BOTH} t_ck;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          fields_seen;
    int          frames_seen;

    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          bytes_sent    = 0;
    int          frames_built  = 0;
    int          settings_used = 1;
    logic [7:0]  cur_class     = CLASS_RESET;
    logic [7:0]  cur_id        = ID_RESET;

    // Frame under construction and its running checksum
    logic [7:0]  frame_bytes [$];
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;

    ubx_nav_pvt_frame_receiver_core #(
        .MAX_PAYLOAD (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ubx_nav_pvt_frame_receiver_core_checker #(
        .MAX_PAYLOAD (MAX_LEN)
    ) u_field_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_fields_seen (fields_seen),
        .o_frames_seen (frames_seen)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #RUN_LIMIT;
        $display("timeout with %0d fields still due", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    task automatic set_idle(input int in_pct, input int out_pct);
        in_idle_pct   <= in_pct;
        out_stall_pct <= out_pct;
    endtask

    // One byte transfer, with random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b, input logic restart);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_data.data_byte <= b;
        i_in_data.restart   <= restart;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Stop sending and let every owed field come out
    task automatic wait_all_fields();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // New class/id setting, read back for the checker
    task automatic set_match(input logic [7:0] cls, input logic [7:0] id);
        apb_write(ADDR_CLASS, {24'h0, cls});
        apb_write(ADDR_ID, {24'h0, id});
        apb_read(ADDR_CLASS);
        apb_read(ADDR_ID);
        cur_class = cls;
        cur_id    = id;
        settings_used++;
    endtask

    task automatic put_summed(input logic [7:0] b);
        frame_bytes.push_back(b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    // Build a whole frame; over-length frames carry only a short tail
    task automatic build_frame(input logic [7:0] cls, input logic [7:0] id,
                               input int len, input t_fill fill, input t_ck ck);
        int          body;
        int          spot;
        int          k;
        logic [7:0]  b;
        logic [7:0]  flip;
        logic [15:0] l16;
        l16  = len[15:0];
        body = (len > MAX_LEN) ? $urandom_range(0, 6) : len;
        spot = (body > 4) ? $urandom_range(0, body - 4) : 0;
        flip = 8'($urandom_range(1, 255));
        frame_bytes.delete();
        sum_a = '0;
        sum_b = '0;
        frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_SECOND);
        put_summed(cls);
        put_summed(id);
        put_summed(l16[7:0]);
        put_summed(l16[15:8]);
        for (k = 0; k < body; k++) begin
            case (fill)
                FILL_ONES:  b = 8'hFF;
                FILL_ZEROS: b = 8'h00;
                default:    b = 8'($urandom_range(0, 255));
            endcase
            // a header hidden in the payload
            if (fill == FILL_SYNCS && body >= 4 && k >= spot && k < spot + 4) begin
                case (k - spot)
                    0:       b = SYNC_FIRST;
                    1:       b = SYNC_SECOND;
                    2:       b = cls;
                    default: b = id;
                endcase
            end
            put_summed(b);
        end
        frame_bytes.push_back((ck == CK_BAD_A || ck == CK_BAD_BOTH) ? sum_a ^ flip : sum_a);
        frame_bytes.push_back((ck == CK_BAD_B || ck == CK_BAD_BOTH) ? sum_b ^ flip : sum_b);
        frames_built++;
    endtask

    // Send the first count bytes of the built frame
    task automatic send_frame(input int count, input logic restart_first);
        int k;
        for (k = 0; k < count; k++) begin
            push_byte(frame_bytes[k], (k == 0) && restart_first);
        end
    endtask

    task automatic send_good(input int len, input t_fill fill, input logic restart_first);
        build_frame(cur_class, cur_id, len, fill, CK_GOOD);
        send_frame(frame_bytes.size(), restart_first);
    endtask

    // Corner cases at the reset class and id
    task automatic run_directed();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        // sync byte followed by something else drops back to hunting
        push_byte(SYNC_FIRST, 1'b0);
        push_byte(8'h17, 1'b0);
        // repeated first sync, then an empty frame
        push_byte(SYNC_FIRST, 1'b0);
        push_byte(SYNC_FIRST, 1'b0);
        send_good(0, FILL_RANDOM, 1'b0);
        // all-ones payload, every signed field reads negative
        send_good(MIN_LEN, FILL_ONES, 1'b0);
        // class and id mismatch
        build_frame(cur_class ^ 8'h80, cur_id, 4, FILL_RANDOM, CK_GOOD);
        send_frame(frame_bytes.size(), 1'b0);
        build_frame(cur_class, ~cur_id, 4, FILL_RANDOM, CK_GOOD);
        send_frame(frame_bytes.size(), 1'b0);
        // length just over the limit
        build_frame(cur_class, cur_id, MAX_LEN + 1, FILL_RANDOM, CK_GOOD);
        send_frame(frame_bytes.size(), 1'b0);
        // checksum failures with a hidden header inside
        build_frame(cur_class, cur_id, 8, FILL_SYNCS, CK_BAD_A);
        send_frame(frame_bytes.size(), 1'b0);
        build_frame(cur_class, cur_id, 8, FILL_SYNCS, CK_BAD_B);
        send_frame(frame_bytes.size(), 1'b0);
        // restart in the payload, then on the closing checksum byte
        build_frame(cur_class, cur_id, 12, FILL_RANDOM, CK_GOOD);
        send_frame(10, 1'b0);
        send_good(8, FILL_RANDOM, 1'b1);
        build_frame(cur_class, cur_id, 8, FILL_RANDOM, CK_GOOD);
        send_frame(frame_bytes.size() - 1, 1'b0);
        push_byte(frame_bytes[frame_bytes.size() - 1], 1'b1);
    endtask

    function automatic t_fill pick_fill();
        case ($urandom_range(9))
            0:       return FILL_ONES;
            1:       return FILL_SYNCS;
            2:       return FILL_ZEROS;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // Mostly good frames, with broken frames and noise in between
    task automatic run_random_phase();
        int         start;
        int         pick;
        int         len;
        int         cut;
        int         k;
        bit         got_long;
        logic [7:0] tweak;
        t_ck        ck;
        start    = bytes_sent;
        got_long = 1'b0;
        while (bytes_sent - start < PHASE_BYTES || !got_long) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if ($urandom_range(3) == 0) begin
                    for (k = $urandom_range(1, 3); k > 0; k--) push_byte(SYNC_FIRST, 1'b0);
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(MIN_LEN, MAX_LEN)
                                               : MIN_LEN + $urandom_range(0, 4);
                send_good(len, pick_fill(), 1'b0);
                got_long = 1'b1;
            end else if (pick < 60) begin
                len = ($urandom_range(4) == 0) ? MIN_LEN - 1 : $urandom_range(0, 12);
                send_good(len, FILL_RANDOM, 1'b0);
            end else if (pick < 70) begin
                case ($urandom_range(2))
                    0:       ck = CK_BAD_A;
                    1:       ck = CK_BAD_B;
                    default: ck = CK_BAD_BOTH;
                endcase
                len = ($urandom_range(3) == 0) ? MIN_LEN : $urandom_range(0, 12);
                build_frame(cur_class, cur_id, len,
                            ($urandom_range(1) == 0) ? FILL_SYNCS : FILL_RANDOM, ck);
                send_frame(frame_bytes.size(), 1'b0);
            end else if (pick < 78) begin
                tweak = 8'($urandom_range(1, 255));
                len   = $urandom_range(0, 12);
                if ($urandom_range(1) == 0) begin
                    build_frame(cur_class ^ tweak, cur_id, len, FILL_RANDOM, CK_GOOD);
                end else begin
                    build_frame(cur_class, cur_id ^ tweak, len, FILL_RANDOM, CK_GOOD);
                end
                send_frame(frame_bytes.size(), 1'b0);
            end else if (pick < 84) begin
                len = ($urandom_range(1) == 0) ? MAX_LEN + 1 : $urandom_range(MAX_LEN + 1, 65535);
                build_frame(cur_class, cur_id, len, FILL_RANDOM, CK_GOOD);
                send_frame(frame_bytes.size(), 1'b0);
            end else if (pick < 92) begin
                // cut a frame short anywhere, then restart on a fresh one
                len = ($urandom_range(3) == 0) ? MIN_LEN : $urandom_range(0, 20);
                build_frame(cur_class, cur_id, len, FILL_RANDOM, CK_GOOD);
                cut = $urandom_range(1, frame_bytes.size() - 1);
                send_frame(cut, 1'b0);
                len = ($urandom_range(3) == 0) ? MIN_LEN : $urandom_range(0, 20);
                send_good(len, FILL_RANDOM, 1'b1);
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    push_byte(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255)),
                              $urandom_range(7) == 0);
                end
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(10, 60);
        run_directed();
        wait_all_fields();

        set_idle(60, 10);
        set_match(8'h00, 8'hFF);
        run_random_phase();
        wait_all_fields();

        // class equal to the first sync byte, id equal to the second
        set_idle(0, 0);
        set_match(SYNC_FIRST, SYNC_SECOND);
        send_good(0, FILL_RANDOM, 1'b0);
        send_good(MIN_LEN, FILL_SYNCS, 1'b0);
        wait_all_fields();

        $display("sent %0d stream bytes in %0d frames plus noise, under %0d class/id settings",
                 bytes_sent, frames_built, settings_used);
        $display("checked %0d decoded fields from %0d frames", fields_seen, frames_seen);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d fields never arrived", errors, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
